/* design/fbcss_pkg.sv */
// ----------------------------------------------------------------------------
// fbcss_pkg
// Types and constants of the forward byte-class sequence search: input and
// result beats, register indexes and the control bundle fed to every cell.
// ----------------------------------------------------------------------------
package fbcss_pkg;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 4;
    localparam int LEN_W     = 5;
    localparam int START_W   = 32;
    localparam int MPOS_W    = 32;
    localparam int TABLE_D   = 256;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_SCAN  = 1'b1;

    localparam logic REG_PATTERN_LEN  = 1'b0;
    localparam logic REG_SEARCH_START = 1'b1;

    typedef struct packed {
        logic              action;
        logic [POS_W-1:0]  class_pos;
        logic [BYTE_W-1:0] class_byte;
        logic              class_member;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } item_t;

    typedef struct packed {
        logic              found;
        logic [MPOS_W-1:0] match_pos;
    } result_t;

    typedef struct packed {
        logic              rd_en;
        logic [BYTE_W-1:0] rd_addr;
        logic [BYTE_W-1:0] wr_addr;
        logic              wr_data;
        logic              step;
        logic              flush;
    } cell_ctrl_t;

endpackage

/* design/fbcss_cell.sv */
// ----------------------------------------------------------------------------
// fbcss_cell
// One pattern position: its byte class column (one bit per byte value) and
// its partial-match bit, fed from the previous position each step.
// ----------------------------------------------------------------------------
module fbcss_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fbcss_pkg::cell_ctrl_t ctrl,
    input  logic                 wr_en,
    input  logic                 prev_in,
    output logic                 hit,
    output logic                 pv_out
);

    logic                         col_mem [fbcss_pkg::TABLE_D];
    logic                         rd_reg;
    logic                         pv_reg;
    logic                         pv_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            col_mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en) begin
            rd_reg <= col_mem[ctrl.rd_addr];
        end
    end

    assign hit = prev_in & rd_reg;

    always_comb begin
        pv_next = pv_reg;
        if (ctrl.step) begin
            pv_next = ctrl.flush ? 1'b0 : hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= pv_next;
        end
    end

    assign pv_out = pv_reg;

endmodule

/* design/forward_byte_class_sequence_search.sv */
// ----------------------------------------------------------------------------
// forward_byte_class_sequence_search
// Shift-and search for the first run of bytes that each fall in the class of
// their pattern position, using a row of cells, one per pattern position.
// ----------------------------------------------------------------------------
//  channel  ports               beat
//  s_       s_valid/s_ready     item_t: class bit write or haystack byte
//  m_       m_valid/m_ready     result_t: found flag and match offset
//  cfg_     cfg_valid/cfg_ready register index and 32-bit data
//
//  One item per cycle while s_ready is high. A haystack byte reads its class
//  bits in every cell as it is taken; any result goes via stage one to the
//  output register once free. After reset a pass over 256 addresses clears the
//  class table; s_ready is low for that time, cfg writes are taken throughout.
//  A held result stalls the input only when a byte waits behind it.
// ----------------------------------------------------------------------------
module forward_byte_class_sequence_search #(
    parameter int MAX_LEN     = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  fbcss_pkg::item_t                  s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output fbcss_pkg::result_t                m_payload,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [fbcss_pkg::START_W-1:0]     cfg_data
);

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DW    = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

    logic [fbcss_pkg::LEN_W-1:0]   pattern_len_reg;
    logic [fbcss_pkg::START_W-1:0] search_start_reg;

    logic                          clr_active_reg;
    logic [fbcss_pkg::BYTE_W-1:0]  clr_addr_reg;

    logic [OFFSET_BITS-1:0]        offset_reg;
    logic [OFFSET_BITS-1:0]        offset_next;

    logic                          s1_valid_reg;
    logic                          s1_last_reg;
    logic                          s1_seed_reg;
    logic [OFFSET_BITS-1:0]        s1_pos_reg;
    logic [IDX_W-1:0]              s1_sel_reg;
    logic [IDX_W-1:0]              sel_next;

    logic                          reported_reg;
    logic                          m_valid_reg;
    fbcss_pkg::result_t            m_payload_reg;

    logic                          s_fire;
    logic                          scan_fire;
    logic                          wr_fire;
    logic                          s1_adv;
    logic                          s1_fire;
    logic                          hit_sel;
    logic                          res_fire;
    logic [DW-1:0]                 diff;

    fbcss_pkg::cell_ctrl_t         ctrl;
    logic [MAX_LEN-1:0]            wr_en;
    logic [MAX_LEN-1:0]            hit;
    logic [MAX_LEN-1:0]            pv;

    assign cfg_ready = 1'b1;

    assign s1_adv    = !m_valid_reg || m_ready;
    assign s1_fire   = s1_valid_reg && s1_adv;
    assign s_ready   = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign s_fire    = s_valid && s_ready;
    assign scan_fire = s_fire && (s_payload.action == fbcss_pkg::ACT_SCAN);
    assign wr_fire   = s_fire && (s_payload.action == fbcss_pkg::ACT_WRITE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_len_reg  <= fbcss_pkg::LEN_W'(1);
            search_start_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fbcss_pkg::REG_PATTERN_LEN: begin
                    pattern_len_reg <= cfg_data[fbcss_pkg::LEN_W-1:0];
                end
                fbcss_pkg::REG_SEARCH_START: begin
                    search_start_reg <= cfg_data;
                end
                default: begin
                    search_start_reg <= search_start_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        if (pattern_len_reg == '0) begin
            sel_next = '0;
        end else if (32'(pattern_len_reg) > MAX_LEN) begin
            sel_next = IDX_W'(MAX_LEN - 1);
        end else begin
            sel_next = IDX_W'(pattern_len_reg - fbcss_pkg::LEN_W'(1));
        end
    end

    always_comb begin
        offset_next = offset_reg;
        if (scan_fire) begin
            if (s_payload.last) begin
                offset_next = '0;
            end else if (offset_reg != '1) begin
                offset_next = offset_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            offset_reg <= offset_next;
            if (scan_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_fire) begin
            s1_last_reg <= s_payload.last;
            s1_seed_reg <= DW'(offset_reg) >= DW'(search_start_reg);
            s1_pos_reg  <= offset_reg;
            s1_sel_reg  <= sel_next;
        end
    end

    always_comb begin
        ctrl.rd_en   = scan_fire;
        ctrl.rd_addr = s_payload.data_byte;
        ctrl.wr_addr = clr_active_reg ? clr_addr_reg : s_payload.class_byte;
        ctrl.wr_data = clr_active_reg ? 1'b0 : s_payload.class_member;
        ctrl.step    = s1_fire;
        ctrl.flush   = s1_last_reg;
    end

    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        assign wr_en[i] = clr_active_reg
                          || (wr_fire && (32'(s_payload.class_pos) == i));
        fbcss_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .wr_en   (wr_en[i]),
            .prev_in ((i == 0) ? s1_seed_reg : pv[(i == 0) ? 0 : i - 1]),
            .hit     (hit[i]),
            .pv_out  (pv[i])
        );
    end

    assign hit_sel  = hit[s1_sel_reg];
    assign res_fire = s1_fire && !reported_reg && (hit_sel || s1_last_reg);
    assign diff     = DW'(s1_pos_reg) - DW'(s1_sel_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reported_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_fire) begin
                if (s1_last_reg) begin
                    reported_reg <= 1'b0;
                end else if (hit_sel) begin
                    reported_reg <= 1'b1;
                end
            end
            if (res_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_fire) begin
            m_payload_reg.found     <= hit_sel;
            m_payload_reg.match_pos <= hit_sel ? fbcss_pkg::MPOS_W'(diff) : '0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef NO_ASSERTIONS
    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_ready)
        else $error("input taken during table clear");

    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_payload_reg.found) |-> (m_payload_reg.match_pos == '0))
        else $error("miss result carries nonzero offset");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_pos_reg)))
        else $error("stalled byte lost from stage one");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_last_reg) |=> !reported_reg)
        else $error("report flag survives end of search");
`endif

endmodule

/* dv/forward_byte_class_sequence_search_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// forward_byte_class_sequence_search_tb
// Drives class table writes and haystack bytes into the shift-and searcher
// with random gaps and output stalls, predicts one outcome per search from
// its own copy of the table and registers, and compares every result beat.
// ----------------------------------------------------------------------------
module forward_byte_class_sequence_search_tb;

    localparam int PAT_MAX     = 16;
    localparam int SCAN_ITEMS  = 650;
    localparam int STALL_LIMIT = 3000;

    class search_tracker;
        logic [PAT_MAX-1:0]            class_bits [fbcss_pkg::TABLE_D];
        logic [PAT_MAX-1:0]            prefix_bits;
        logic [31:0]                   offset;
        bit                            reported;
        logic [fbcss_pkg::LEN_W-1:0]   pattern_len;
        logic [fbcss_pkg::START_W-1:0] search_start;
        fbcss_pkg::result_t            expected_outcomes [$];
        int                            errors;

        function new();
            foreach (class_bits[i]) class_bits[i] = '0;
            prefix_bits  = '0;
            offset       = '0;
            reported     = 1'b0;
            pattern_len  = fbcss_pkg::LEN_W'(1);
            search_start = '0;
            errors       = 0;
        endfunction

        function void set_reg(logic idx, logic [fbcss_pkg::START_W-1:0] data);
            if (idx == fbcss_pkg::REG_PATTERN_LEN) begin
                pattern_len = data[fbcss_pkg::LEN_W-1:0];
            end else begin
                search_start = data;
            end
        endfunction

        function void take_item(fbcss_pkg::item_t it);
            int                 len;
            fbcss_pkg::result_t r;
            if (it.action == fbcss_pkg::ACT_WRITE) begin
                class_bits[it.class_byte][it.class_pos] = it.class_member;
                return;
            end
            if (pattern_len == 0) begin
                len = 1;
            end else if (int'(pattern_len) > PAT_MAX) begin
                len = PAT_MAX;
            end else begin
                len = int'(pattern_len);
            end
            prefix_bits = {prefix_bits[PAT_MAX-2:0], offset >= search_start}
                          & class_bits[it.data_byte];
            if (!reported) begin
                if (prefix_bits[len-1]) begin
                    r.found     = 1'b1;
                    r.match_pos = offset - fbcss_pkg::MPOS_W'(len - 1);
                    expected_outcomes.push_back(r);
                    reported = 1'b1;
                end else if (it.last) begin
                    r = '0;
                    expected_outcomes.push_back(r);
                end
            end
            // saturate the offset
            if (offset != '1) offset = offset + 32'd1;
            if (it.last) begin
                prefix_bits = '0;
                offset      = '0;
                reported    = 1'b0;
            end
        endfunction

        function void check_result(fbcss_pkg::result_t got);
            fbcss_pkg::result_t want;
            if (expected_outcomes.size() == 0) begin
                $error("result with none expected: found %0b match_pos %0d",
                       got.found, got.match_pos);
                errors++;
                return;
            end
            want = expected_outcomes.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0b, got %0b", want.found, got.found);
                errors++;
            end
            if (got.match_pos !== want.match_pos) begin
                $error("match_pos: expected %0d, got %0d", want.match_pos, got.match_pos);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_outcomes.size();
        endfunction
    endclass

    bit                            aclk;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    fbcss_pkg::item_t              s_payload = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    fbcss_pkg::result_t            m_payload;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic                          cfg_index = fbcss_pkg::REG_PATTERN_LEN;
    logic [fbcss_pkg::START_W-1:0] cfg_data  = '0;

    search_tracker                tracker;
    bit                           quiet;
    int                           ready_hold;
    int                           stall_cycles;
    int                           stim_count;
    logic [fbcss_pkg::BYTE_W-1:0] alphabet [4];

    forward_byte_class_sequence_search #(
        .MAX_LEN     (PAT_MAX),
        .OFFSET_BITS (32)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic fbcss_pkg::item_t class_write(int pos,
                                                     logic [fbcss_pkg::BYTE_W-1:0] b,
                                                     bit member);
        fbcss_pkg::item_t it;
        it.action       = fbcss_pkg::ACT_WRITE;
        it.class_pos    = fbcss_pkg::POS_W'(pos);
        it.class_byte   = b;
        it.class_member = member;
        it.data_byte    = fbcss_pkg::BYTE_W'($urandom_range(0, 255));
        it.last         = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic fbcss_pkg::item_t scan_byte(logic [fbcss_pkg::BYTE_W-1:0] b,
                                                   bit is_last);
        fbcss_pkg::item_t it;
        it.action       = fbcss_pkg::ACT_SCAN;
        it.class_pos    = fbcss_pkg::POS_W'($urandom_range(0, 15));
        it.class_byte   = fbcss_pkg::BYTE_W'($urandom_range(0, 255));
        it.class_member = 1'($urandom_range(0, 1));
        it.data_byte    = b;
        it.last         = is_last;
        return it;
    endfunction

    function automatic logic [fbcss_pkg::BYTE_W-1:0] pick_symbol();
        if ($urandom_range(0, 6) == 0) return fbcss_pkg::BYTE_W'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, 3)];
    endfunction

    task automatic send_item(input fbcss_pkg::item_t it);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        stim_count++;
    endtask

    task automatic write_reg(input logic idx, input logic [fbcss_pkg::START_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // hold until every outcome is in and the pipeline has emptied
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 1) == 1) begin
            m_ready <= 1'b1;
            ready_hold = $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b0;
            ready_hold = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) tracker.take_item(s_payload);
            if (cfg_valid && cfg_ready) tracker.set_reg(cfg_index, cfg_data);
            if (m_valid && m_ready) tracker.check_result(m_payload);
            if ((s_valid && s_ready) || (cfg_valid && cfg_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("forward_byte_class_sequence_search_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        int                            pl;
        int                            eff;
        int                            nbytes;
        logic [fbcss_pkg::START_W-1:0] start;
        tracker = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_reg(fbcss_pkg::REG_PATTERN_LEN, 1);
        write_reg(fbcss_pkg::REG_SEARCH_START, 0);
        send_item(scan_byte(8'h41, 1'b1));
        send_item(class_write(0, 8'h00, 1'b1));
        send_item(class_write(15, 8'hFF, 1'b1));
        send_item(class_write(0, 8'hFF, 1'b1));
        // match mid-search, then the rest of the haystack stays silent
        send_item(scan_byte(8'h10, 1'b0));
        send_item(scan_byte(8'hFF, 1'b0));
        send_item(scan_byte(8'h00, 1'b0));
        send_item(scan_byte(8'h00, 1'b1));
        send_item(scan_byte(8'h00, 1'b1));
        send_item(class_write(0, 8'hFF, 1'b0));
        send_item(scan_byte(8'hFF, 1'b1));
        send_item(scan_byte(8'h77, 1'b0));
        send_item(class_write(0, 8'h77, 1'b1));
        send_item(scan_byte(8'h77, 1'b1));
        drain();
        write_reg(fbcss_pkg::REG_PATTERN_LEN, 0);
        write_reg(fbcss_pkg::REG_SEARCH_START, 32'hFFFF_FFFF);
        send_item(scan_byte(8'h00, 1'b0));
        send_item(scan_byte(8'h00, 1'b1));
        drain();
        write_reg(fbcss_pkg::REG_PATTERN_LEN, 2);
        write_reg(fbcss_pkg::REG_SEARCH_START, 2);
        send_item(class_write(1, 8'h00, 1'b1));
        repeat (3) send_item(scan_byte(8'h00, 1'b0));
        send_item(scan_byte(8'h00, 1'b1));

        stim_count = 0;
        while (stim_count < SCAN_ITEMS) begin
            drain();
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0:       pl = 0;
                1:       pl = $urandom_range(17, 31);
                2:       pl = PAT_MAX;
                default: pl = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 9))
                6, 7:    start = $urandom_range(1, 30);
                8:       start = 32'hFFFF_FFFF;
                9:       start = $urandom;
                default: start = 0;
            endcase
            write_reg(fbcss_pkg::REG_PATTERN_LEN, pl);
            write_reg(fbcss_pkg::REG_SEARCH_START, start);
            eff = (pl == 0) ? 1 : (pl > PAT_MAX) ? PAT_MAX : pl;
            foreach (alphabet[i]) begin
                case ($urandom_range(0, 5))
                    0:       alphabet[i] = 8'h00;
                    1:       alphabet[i] = 8'hFF;
                    default: alphabet[i] = fbcss_pkg::BYTE_W'($urandom_range(0, 255));
                endcase
            end
            // load classes dense enough that long patterns still match now and then
            for (int p = 0; p < eff; p++) begin
                foreach (alphabet[a]) begin
                    send_item(class_write(p, alphabet[a], $urandom_range(0, eff + 3) != 0));
                end
            end
            repeat ($urandom_range(3, 8)) begin
                nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12);
                for (int k = 1; k <= nbytes; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_item(class_write($urandom_range(0, 15), pick_symbol(),
                                              1'($urandom_range(0, 1))));
                    end
                    send_item(scan_byte(pick_symbol(), k == nbytes));
                end
            end
        end

        drain();
        if (tracker.errors == 0) begin
            $display("forward_byte_class_sequence_search_tb: clean");
        end else begin
            $display("forward_byte_class_sequence_search_tb: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/fbcss_pkg.sv
design/fbcss_cell.sv
design/forward_byte_class_sequence_search.sv
dv/forward_byte_class_sequence_search_tb.sv
